[src/sm3_hash_engine_defines.svh]
// Assertion helpers for the SM3 engine
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

`define SM3_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: label failed");

`define SM3_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: label failed");

`endif

[src/sm3_pkg.sv]
`default_nettype none
package sm3_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;

  localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
  localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // word sources for the block buffer
  localparam logic [1:0] SRC_MSG  = 2'd0;
  localparam logic [1:0] SRC_ZERO = 2'd1;
  localparam logic [1:0] SRC_LENH = 2'd2;
  localparam logic [1:0] SRC_LENL = 2'd3;

  typedef struct packed {
    logic       push;      // write one word into the block buffer
    logic [1:0] src;
    logic       pad4;      // message word is full, pad word is next
    logic       add_len;
    logic       rnd_start; // load A..H from chaining value
    logic       rnd_step;
    logic       fold;      // chaining value ^= A..H
    logic       reinit;    // restore IV, clear length
    logic       shift_out;
  } ctrl_t;

  typedef struct packed {
    logic [4:0] words;
    logic       round_last;
  } stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

[src/sm3_datapath.sv]
`default_nettype none
module sm3_datapath #(
  parameter int unsigned LENGTH_BITS = sm3_pkg::LENGTH_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sm3_pkg::ctrl_t ctrl,
  output sm3_pkg::stat_t     stat,
  input  wire logic [31:0]   msg_word,
  input  wire logic [2:0]    byte_count,
  input  wire logic          last_piece,
  output logic [31:0]        out_word
);

  logic [31:0] cv [8];
  logic [31:0] r [8];
  logic [31:0] win [16];   // sliding W window, W[j] at win[0]
  logic [60:0] length_bytes;
  logic [4:0]  words;
  logic [5:0]  round_index;
  logic [2:0]  cnt;
  logic [31:0] keep, pad_word, msg_in, push_val, wnew;
  logic [63:0] bits;
  logic [LENGTH_BITS-1:0] bits_red;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    cnt = (!last_piece || byte_count > 3'd4) ? 3'd4 : byte_count;
    case (cnt)
      3'd0: keep = 32'h0;
      3'd1: keep = 32'hFF000000;
      3'd2: keep = 32'hFFFF0000;
      3'd3: keep = 32'hFFFFFF00;
      default: keep = 32'hFFFFFFFF;
    endcase
    case (cnt)
      3'd0: pad_word = {sm3_pkg::PAD_BYTE, 24'h0};
      3'd1: pad_word = {8'h0, sm3_pkg::PAD_BYTE, 16'h0};
      3'd2: pad_word = {16'h0, sm3_pkg::PAD_BYTE, 8'h0};
      3'd3: pad_word = {24'h0, sm3_pkg::PAD_BYTE};
      default: pad_word = 32'h0;
    endcase
    msg_in = last_piece ? ((msg_word & keep) | pad_word) : msg_word;
    bits_red = LENGTH_BITS'({length_bytes, 3'b000});
    bits = 64'(bits_red);
    case (ctrl.src)
      sm3_pkg::SRC_MSG:  push_val = ctrl.pad4 ? {sm3_pkg::PAD_BYTE, 24'h0} : msg_in;
      sm3_pkg::SRC_LENH: push_val = bits[63:32];
      sm3_pkg::SRC_LENL: push_val = bits[31:0];
      default:           push_val = 32'h0;
    endcase
  end

  always_comb begin
    tj  = (round_index < 6'd16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
    a12 = sm3_pkg::rotl(r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r[4] + sm3_pkg::rotl(tj, round_index[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round_index < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + r[7] + ss1 + win[0];
    wnew = sm3_pkg::p1(win[0] ^ win[7] ^ sm3_pkg::rotl(win[13], 5'd15))
         ^ sm3_pkg::rotl(win[3], 5'd7) ^ win[10];
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      win[words[3:0]] <= push_val;
    end else if (ctrl.rnd_step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) cv[i] <= sm3_pkg::IV[i];
      for (int i = 0; i < 8; i++) r[i] <= 32'h0;
      length_bytes <= '0;
      words <= '0;
      round_index <= '0;
    end else begin
      if (ctrl.reinit) length_bytes <= '0;
      else if (ctrl.add_len) length_bytes <= length_bytes + 61'(cnt);

      if (ctrl.rnd_start || ctrl.reinit) words <= '0;
      else if (ctrl.push) words <= words + 5'd1;

      if (ctrl.rnd_start || ctrl.fold) round_index <= '0;
      else if (ctrl.rnd_step) round_index <= round_index + 6'd1;

      if (ctrl.rnd_start) begin
        for (int i = 0; i < 8; i++) r[i] <= cv[i];
      end else if (ctrl.rnd_step) begin
        r[3] <= r[2];
        r[2] <= sm3_pkg::rotl(r[1], 5'd9);
        r[1] <= r[0];
        r[0] <= tt1;
        r[7] <= r[6];
        r[6] <= sm3_pkg::rotl(r[5], 5'd19);
        r[5] <= r[4];
        r[4] <= sm3_pkg::p0(tt2);
      end

      if (ctrl.reinit) begin
        for (int i = 0; i < 8; i++) cv[i] <= sm3_pkg::IV[i];
      end else if (ctrl.fold) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ r[i];
      end else if (ctrl.shift_out) begin
        for (int i = 0; i < 7; i++) cv[i] <= cv[i+1];
        cv[7] <= cv[0];
      end
    end
  end

  assign out_word = cv[0];
  assign stat.words = words;
  assign stat.round_last = (round_index == 6'd63);

endmodule
`default_nettype wire

[src/sm3_ctrl.sv]
`default_nettype none
module sm3_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           last_piece,
  input  wire logic [2:0]     byte_count,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_last,
  output sm3_pkg::ctrl_t      ctrl,
  input  wire sm3_pkg::stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD4 = 3'd1;  // push 0x80 word after full last word
  localparam logic [2:0] S_FILL = 3'd2;  // zero fill and length words
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic       fin, fin_next;     // padding in progress for this message
  logic [2:0] ocnt, ocnt_next;
  logic       acc, full_after;
  // high length word written, low one goes at the end of this block
  logic       pad_done, pad_done_next;
  // full last word closed a block, 0x80 word still to push
  logic       pad_owed, pad_owed_next;

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_last = (ocnt == 3'd7);
  assign full_after = (stat.words == 5'd15);

  always_comb begin
    ctrl = '0;
    state_next = state;
    fin_next = fin;
    ocnt_next = ocnt;
    pad_owed_next = pad_owed;
    case (state)
      S_IDLE: begin
        if (acc) begin
          ctrl.push = 1'b1;
          ctrl.src = sm3_pkg::SRC_MSG;
          ctrl.add_len = 1'b1;
          if (last_piece) begin
            fin_next = 1'b1;
            if (full_after) begin
              ctrl.rnd_start = 1'b0;
              state_next = S_ROUND;
            end else begin
              state_next = (byte_count >= 3'd4) ? S_PAD4 : S_FILL;
            end
            if (full_after && byte_count >= 3'd4) pad_owed_next = 1'b1;
          end else if (full_after) begin
            state_next = S_ROUND;
          end
        end
      end
      S_PAD4: begin
        ctrl.push = 1'b1;
        ctrl.src = sm3_pkg::SRC_MSG;
        ctrl.pad4 = 1'b1;
        state_next = full_after ? S_ROUND : S_FILL;
      end
      S_FILL: begin
        ctrl.push = 1'b1;
        if (stat.words == 5'd14) ctrl.src = sm3_pkg::SRC_LENH;
        else if (stat.words == 5'd15 && pad_done) ctrl.src = sm3_pkg::SRC_LENL;
        else ctrl.src = sm3_pkg::SRC_ZERO;
        if (full_after) state_next = S_ROUND;
      end
      S_ROUND: begin
        ctrl.rnd_step = 1'b1;
        if (stat.round_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        ctrl.fold = 1'b1;
        if (fin && stat.words == 5'd0 && pad_done) begin
          state_next = S_OUT;
        end else if (fin && pad_owed) begin
          pad_owed_next = 1'b0;
          state_next = S_PAD4;
        end else if (fin) begin
          state_next = S_FILL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ctrl.shift_out = 1'b1;
          ocnt_next = ocnt + 3'd1;
          if (ocnt == 3'd7) begin
            ctrl.reinit = 1'b1;
            fin_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state_next == S_ROUND && state != S_ROUND) ctrl.rnd_start = 1'b1;
  end

  always_comb begin
    pad_done_next = pad_done;
    if (state == S_FILL && stat.words == 5'd14) pad_done_next = 1'b1;
    if (state == S_OUT) pad_done_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
      ocnt <= '0;
      pad_done <= 1'b0;
      pad_owed <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      ocnt <= ocnt_next;
      pad_done <= pad_done_next;
      pad_owed <= pad_owed_next;
    end
  end

endmodule
`default_nettype wire

[src/sm3_hash_engine.sv]
// SM3 hash engine. Message words (big-endian, valid bytes left-aligned)
// enter on msg_word with byte_count and last_piece; eight digest words leave
// most significant first, last_word on the eighth. One word is taken per
// cycle until a 512-bit block is full, then the block is compressed one
// round per cycle on the shared round unit and folded into the chaining
// value, during which no input is taken. The final word adds padding words
// and one or two compressions before the digest is shown.
`default_nettype none
`include "sm3_hash_engine_defines.svh"
module sm3_hash_engine #(
  parameter int unsigned LENGTH_BITS = sm3_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] msg_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last_piece,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  sm3_pkg::ctrl_t ctrl;
  sm3_pkg::stat_t stat;

  sm3_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk, .rst, .ctrl, .stat, .msg_word, .byte_count, .last_piece,
    .out_word(digest_word)
  );

  sm3_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_piece, .byte_count,
    .out_valid, .out_ready, .out_last(last_word), .ctrl, .stat
  );

  `SM3_ASSERT_IMPL(no_in_while_out, clk, rst, out_valid, !in_ready)
  `SM3_ASSERT_NEXT(out_holds, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(digest_word))
  `SM3_ASSERT_IMPL(rounds_block_input, clk, rst, ctrl.rnd_step, !in_ready)

endmodule
`default_nettype wire
